// File: hw/rtl/assert_macros.svh
// Assertion helpers for the block allocator.
// Define ASSERT_OFF to compile the assertions out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Check a property on every rising edge, skipped while reset is high.
`define FBA_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("fba assertion failed");

// Check a property on every rising edge, reset included.
`define FBA_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) (prop)) \
      else $error("fba assertion failed");

`else

`define FBA_ASSERT(lbl, clk, rst, prop)
`define FBA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: hw/rtl/fba_pkg.sv
package fba_pkg;

   localparam int NUM_ENTRIES      = 2048;
   localparam int FIRST_DATA_BLOCK = 2;

   localparam int ADDR_W   = $clog2(NUM_ENTRIES);
   localparam int CNT_W    = $clog2(NUM_ENTRIES + 1);
   localparam int ENTRY_W  = 16;
   localparam int BLOCK_W  = 11;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   localparam logic [ENTRY_W-1:0] ENTRY_FREE = 16'h0000;
   localparam logic [ENTRY_W-1:0] ENTRY_END  = 16'hFFFF;

   localparam logic [ENTRY_W-1:0] NUM_ENTRIES_E = ENTRY_W'(NUM_ENTRIES);
   localparam logic [ENTRY_W-1:0] FIRST_DATA_E  = ENTRY_W'(FIRST_DATA_BLOCK);
   localparam logic [CNT_W-1:0]   NUM_ENTRIES_C = CNT_W'(NUM_ENTRIES);
   localparam logic [CNT_W-1:0]   FIRST_DATA_C  = CNT_W'(FIRST_DATA_BLOCK);
   localparam logic [CNT_W-1:0]   LAST_ENTRY_C  = CNT_W'(NUM_ENTRIES - 1);

   typedef enum logic [CMD_W-1:0] {
      CMD_FORMAT = 3'd0,
      CMD_ALLOC  = 3'd1,
      CMD_FREE   = 3'd2,
      CMD_READ   = 3'd3,
      CMD_FIND   = 3'd4
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_FAULT = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_LINK,
      S_WALK,
      S_READ,
      S_RESP
   } state_type;

   typedef struct packed {
      logic               we;
      logic [ADDR_W-1:0]  waddr;
      logic [ENTRY_W-1:0] wdata;
      logic [ADDR_W-1:0]  raddr;
   } mem_req_type;

   typedef struct packed {
      status_type         status;
      logic [BLOCK_W-1:0] block;
      logic [ENTRY_W-1:0] entry;
   } result_type;

   // A block may sit in a chain only inside the table and past the reserved entries.
   function automatic logic chain_ok(input logic [ENTRY_W-1:0] b);
      return (b < NUM_ENTRIES_E) && (b >= FIRST_DATA_E);
   endfunction

endpackage

// File: hw/rtl/fba_ram.sv
module fba_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hw/rtl/fba_ctrl.sv
`include "assert_macros.svh"

module fba_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fba_pkg::CMD_W-1:0]    req_cmd,
   input  logic [fba_pkg::BLOCK_W-1:0]  req_block,
   input  logic                         req_link,
   input  logic [fba_pkg::BLOCK_W-1:0]  req_prev,
   output logic                         res_valid,
   output fba_pkg::result_type          res,
   input  logic                         res_free,
   output fba_pkg::mem_req_type         mem_req,
   input  logic [fba_pkg::ENTRY_W-1:0]  mem_rdata
);

   import fba_pkg::*;

   state_type            state_ff, state_in;
   cmd_type              cmd_ff, cmd_in;
   logic                 link_ff, link_in;
   logic [BLOCK_W-1:0]   prev_ff, prev_in;
   logic [ENTRY_W-1:0]   cur_ff, cur_in;
   logic [CNT_W-1:0]     scan_ff, scan_in;
   logic [CNT_W-1:0]     steps_ff, steps_in;
   logic [CNT_W-1:0]     hint_ff, hint_in;
   logic [CNT_W-1:0]     clr_ff, clr_in;
   logic                 clr_rsp_ff, clr_rsp_in;
   result_type           res_ff, res_in;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic [ENTRY_W-1:0]   fwd_data_ff, fwd_data_in;

   logic [ENTRY_W-1:0]   rd_data;
   logic [ENTRY_W-1:0]   blk_e;
   logic [CNT_W-1:0]     scan_nxt;
   logic [CNT_W-1:0]     steps_nxt;

   // Entry written in the cycle it was read comes from the bypass, not the RAM.
   assign rd_data   = fwd_hit_ff ? fwd_data_ff : mem_rdata;
   assign blk_e     = ENTRY_W'(req_block);
   assign scan_nxt  = scan_ff + CNT_W'(1);
   assign steps_nxt = steps_ff + CNT_W'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_RESP) && res_free;
   assign res       = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_ff     <= '0;
         clr_rsp_ff <= 1'b0;
         hint_ff    <= FIRST_DATA_C;
         fwd_hit_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         clr_rsp_ff <= clr_rsp_in;
         hint_ff    <= hint_in;
         fwd_hit_ff <= fwd_hit_in;
      end
      cmd_ff      <= cmd_in;
      link_ff     <= link_in;
      prev_ff     <= prev_in;
      cur_ff      <= cur_in;
      scan_ff     <= scan_in;
      steps_ff    <= steps_in;
      res_ff      <= res_in;
      fwd_data_ff <= fwd_data_in;
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      link_in       = link_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      scan_in       = scan_ff;
      steps_in      = steps_ff;
      hint_in       = hint_ff;
      clr_in        = clr_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_in        = res_ff;
      mem_req.we    = 1'b0;
      mem_req.waddr = cur_ff[ADDR_W-1:0];
      mem_req.wdata = ENTRY_FREE;
      mem_req.raddr = cur_ff[ADDR_W-1:0];

      unique case (state_ff)
         S_CLEAR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = clr_ff[ADDR_W-1:0];
            mem_req.wdata = (clr_ff < FIRST_DATA_C) ? ENTRY_END : ENTRY_FREE;
            clr_in        = clr_ff + CNT_W'(1);
            hint_in       = FIRST_DATA_C;
            if (clr_ff == LAST_ENTRY_C) begin
               clr_in     = '0;
               clr_rsp_in = 1'b0;
               res_in     = '{status: ST_OK, block: '0, entry: '0};
               state_in   = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end

         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = cmd_type'(req_cmd);
               link_in  = req_link;
               prev_in  = req_prev;
               steps_in = '0;
               res_in   = '{status: ST_OK, block: '0, entry: '0};
               state_in = S_RESP;
               case (cmd_type'(req_cmd))
                  CMD_FORMAT: begin
                     clr_in     = '0;
                     clr_rsp_in = 1'b1;
                     state_in   = S_CLEAR;
                  end
                  CMD_ALLOC: begin
                     if (hint_ff == NUM_ENTRIES_C) begin
                        res_in.status = ST_FULL;
                     end else begin
                        mem_req.raddr = hint_ff[ADDR_W-1:0];
                        scan_in       = hint_ff;
                        state_in      = S_SCAN;
                     end
                  end
                  CMD_FREE, CMD_FIND: begin
                     if (!chain_ok(blk_e)) begin
                        res_in.status = ST_FAULT;
                        res_in.block  = req_block;
                     end else begin
                        mem_req.raddr = blk_e[ADDR_W-1:0];
                        cur_in        = blk_e;
                        state_in      = S_WALK;
                     end
                  end
                  CMD_READ: begin
                     if (blk_e < NUM_ENTRIES_E) begin
                        mem_req.raddr = blk_e[ADDR_W-1:0];
                        cur_in        = blk_e;
                        state_in      = S_READ;
                     end else begin
                        res_in.status = ST_FAULT;
                        res_in.block  = req_block;
                     end
                  end
                  default: ;
               endcase
            end
         end

         S_SCAN: begin
            if (rd_data == ENTRY_FREE) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = scan_ff[ADDR_W-1:0];
               mem_req.wdata = ENTRY_END;
               hint_in       = scan_nxt;
               res_in        = '{status: ST_OK, block: BLOCK_W'(scan_ff), entry: '0};
               // A link onto the new block itself leaves it an end marker.
               if (link_ff && (ENTRY_W'(prev_ff) < NUM_ENTRIES_E) &&
                   (CNT_W'(prev_ff) != scan_ff)) begin
                  state_in = S_LINK;
               end else begin
                  state_in = S_RESP;
               end
            end else if (scan_nxt == NUM_ENTRIES_C) begin
               hint_in  = NUM_ENTRIES_C;
               res_in   = '{status: ST_FULL, block: '0, entry: '0};
               state_in = S_RESP;
            end else begin
               mem_req.raddr = scan_nxt[ADDR_W-1:0];
               scan_in       = scan_nxt;
            end
         end

         S_LINK: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ADDR_W'(prev_ff);
            mem_req.wdata = ENTRY_W'(scan_ff);
            state_in      = S_RESP;
         end

         S_WALK: begin
            if (rd_data == ENTRY_FREE) begin
               res_in   = '{status: ST_FAULT, block: BLOCK_W'(cur_ff), entry: '0};
               state_in = S_RESP;
            end else begin
               if (cmd_ff == CMD_FREE) begin
                  mem_req.we    = 1'b1;
                  mem_req.waddr = cur_ff[ADDR_W-1:0];
                  mem_req.wdata = ENTRY_FREE;
                  if (cur_ff[CNT_W-1:0] < hint_ff) begin
                     hint_in = cur_ff[CNT_W-1:0];
                  end
               end
               steps_in = steps_nxt;
               if (rd_data == ENTRY_END) begin
                  res_in   = '{status: ST_OK, block: BLOCK_W'(cur_ff), entry: '0};
                  state_in = S_RESP;
               end else if ((steps_nxt == NUM_ENTRIES_C) || !chain_ok(rd_data)) begin
                  res_in   = '{status: ST_FAULT, block: BLOCK_W'(rd_data), entry: '0};
                  state_in = S_RESP;
               end else begin
                  mem_req.raddr = rd_data[ADDR_W-1:0];
                  cur_in        = rd_data;
               end
            end
         end

         S_READ: begin
            res_in   = '{status: ST_OK, block: BLOCK_W'(cur_ff), entry: rd_data};
            state_in = S_RESP;
         end

         S_RESP: begin
            if (res_free) begin
               state_in = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase

      fwd_hit_in  = mem_req.we && (mem_req.waddr == mem_req.raddr);
      fwd_data_in = mem_req.wdata;
   end

   `FBA_ASSERT(a_walk_write_only_free, clock, reset, (state_ff == S_WALK && mem_req.we) |-> (cmd_ff == CMD_FREE))
   `FBA_ASSERT(a_steps_bound, clock, reset, (state_ff == S_WALK) |-> (steps_ff < NUM_ENTRIES_C))
   `FBA_ASSERT(a_hint_range, clock, reset, (hint_ff >= FIRST_DATA_C) && (hint_ff <= NUM_ENTRIES_C))
   `FBA_ASSERT(a_clear_after_reset, clock, reset, $fell(reset) |-> (state_ff == S_CLEAR && clr_ff == '0))
   `FBA_ASSERT(a_scan_from_hint, clock, reset, (state_ff == S_SCAN) |-> (scan_ff >= hint_ff))

endmodule

// File: hw/rtl/fat_block_allocator.sv
// Channel   Dir  Payload (low bit up)                                   Beat when
// req       in   tuser: cmd[2:0]                                         req_tvalid & req_tready
//                tdata: block[10:0] link_prev[11] prev_block[22:12] pad
// rsp       out  tuser: status[1:0]                                      rsp_tvalid & rsp_tready
//                tdata: block_out[10:0] entry_out[26:11] pad
//
// One command at a time; req_tready is high only while the controller is idle.
// Allocate scans the table one entry at a time from the lowest possibly free block
// (with one more write for a link), chain commands walk one block at a time, and
// format rewrites every entry of the single table RAM.
// After reset a clearing pass writes the whole table before the first req beat is
// taken. A stalled rsp holds at the output register while the next command is taken
// and run; its result waits until the register drains.
module fat_block_allocator (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [fba_pkg::REQ_TDATA_W-1:0]  req_tdata,  // block, link_prev, prev_block
   input  logic [fba_pkg::CMD_W-1:0]        req_tuser,  // cmd
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [fba_pkg::RSP_TDATA_W-1:0]  rsp_tdata,  // block_out, entry_out
   output logic [fba_pkg::STATUS_W-1:0]     rsp_tuser   // status
);

   import fba_pkg::*;

   logic                rsp_valid_ff, rsp_valid_in;
   result_type          rsp_res_ff, rsp_res_in;
   logic                res_valid;
   result_type          res;
   logic                res_free;
   mem_req_type         mem_req;
   logic [ENTRY_W-1:0]  mem_rdata;

   assign res_free = !rsp_valid_ff || rsp_tready;

   fba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_cmd   (req_tuser),
      .req_block (req_tdata[BLOCK_W-1:0]),
      .req_link  (req_tdata[BLOCK_W]),
      .req_prev  (req_tdata[2*BLOCK_W:BLOCK_W+1]),
      .res_valid (res_valid),
      .res       (res),
      .res_free  (res_free),
      .mem_req   (mem_req),
      .mem_rdata (mem_rdata)
   );

   fba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (mem_req.we),
      .waddr (mem_req.waddr),
      .wdata (mem_req.wdata),
      .raddr (mem_req.raddr),
      .rdata (mem_rdata)
   );

   // Load a fresh result, else drop the beat once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_res_ff <= rsp_res_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.status;
   assign rsp_tdata  = {{(RSP_TDATA_W - BLOCK_W - ENTRY_W){1'b0}},
                        rsp_res_ff.entry, rsp_res_ff.block};

endmodule

// File: tb/testbench.sv
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import fba_pkg::*;

   // command codes the block does not decode
   localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
   localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

   localparam int POOL_SIZE   = 16;
   localparam int MAX_REPORTS = 10;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      status_type         status;
      logic [BLOCK_W-1:0] blk;
      logic [ENTRY_W-1:0] entry;
   } fat_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;  // block[10:0], link_prev[11], prev_block[22:12]
   logic [CMD_W-1:0]       req_tuser  = '0;  // cmd[2:0]
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // block_out[10:0], entry_out[26:11]
   logic [STATUS_W-1:0]    rsp_tuser;        // status[1:0]

   // shadow of the allocation table and the replies still owed by the block
   logic [ENTRY_W-1:0] fat_copy [NUM_ENTRIES];
   fat_result_type     pending_replies[$];

   // recently allocated blocks, used to aim commands at live chains
   logic [BLOCK_W-1:0] alloc_pool [POOL_SIZE];
   int                 pool_count = 0;
   int                 pool_wr    = 0;
   logic [BLOCK_W-1:0] last_alloc = '0;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_len      = 0;
   bit rsp_hold      = 1'b0;

   int fail_count  = 0;
   int cmds_sent   = 0;
   int replies_ok  = 0;
   int fault_count = 0;
   int full_count  = 0;

   fat_block_allocator dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic void format_copy();
      for (int i = 0; i < NUM_ENTRIES; i++)
         fat_copy[i] = (i < FIRST_DATA_BLOCK) ? ENTRY_END : ENTRY_FREE;
   endfunction

   function automatic int lowest_free();
      for (int i = FIRST_DATA_BLOCK; i < NUM_ENTRIES; i++)
         if (fat_copy[i] == ENTRY_FREE) return i;
      return -1;
   endfunction

   function automatic fat_result_type predict_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [BLOCK_W-1:0] blk,
                                                      input logic link,
                                                      input logic [BLOCK_W-1:0] prev);
      fat_result_type     r;
      int                 slot;
      logic [ENTRY_W-1:0] cur;
      logic [ENTRY_W-1:0] nxt;
      bit                 done;
      r.status = ST_OK;
      r.blk    = '0;
      r.entry  = '0;
      case (cmd)
         CMD_FORMAT: format_copy();
         CMD_ALLOC: begin
            slot = lowest_free();
            if (slot < 0) begin
               r.status = ST_FULL;
            end else begin
               if (link && int'(prev) < NUM_ENTRIES) fat_copy[prev] = ENTRY_W'(slot);
               fat_copy[slot] = ENTRY_END;
               r.blk = BLOCK_W'(slot);
            end
         end
         CMD_FREE, CMD_FIND: begin
            cur      = ENTRY_W'(blk);
            done     = 1'b0;
            r.status = ST_FAULT;
            for (int steps = 0; steps < NUM_ENTRIES && !done; steps++) begin
               if (cur >= NUM_ENTRIES_E || cur < FIRST_DATA_E) begin
                  done = 1'b1;
               end else begin
                  nxt = fat_copy[cur];
                  if (nxt == ENTRY_FREE) begin
                     done = 1'b1;
                  end else begin
                     if (cmd == CMD_FREE) fat_copy[cur] = ENTRY_FREE;
                     if (nxt == ENTRY_END) begin
                        r.status = ST_OK;
                        done     = 1'b1;
                     end else begin
                        cur = nxt;
                     end
                  end
               end
            end
            r.blk = cur[BLOCK_W-1:0];
         end
         CMD_READ: begin
            r.blk = blk;
            if (int'(blk) < NUM_ENTRIES) r.entry = fat_copy[blk];
            else r.status = ST_FAULT;
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
   endfunction

   task automatic check_reply();
      fat_result_type want;
      fat_result_type got;
      got.status = status_type'(rsp_tuser);
      got.blk    = rsp_tdata[10:0];
      got.entry  = rsp_tdata[26:11];
      if (pending_replies.size() == 0) begin
         note_failure($sformatf("reply with nothing pending: status %0d block %0d entry %h",
                                rsp_tuser, got.blk, got.entry));
      end else begin
         want = pending_replies.pop_front();
         replies_ok++;
         if (want.status == ST_FAULT) fault_count++;
         if (want.status == ST_FULL) full_count++;
         if (rsp_tuser !== want.status || got.blk !== want.blk || got.entry !== want.entry)
            note_failure($sformatf(
               "reply %0d: want status %0d block %0d entry %h, got status %0d block %0d entry %h",
               replies_ok, want.status, want.blk, want.entry, rsp_tuser, got.blk, got.entry));
      end
   endtask

   // check each beat, then pick the next ready level
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_reply();
      rsp_tready <= !rsp_hold && ($urandom_range(99) >= rsp_stall_pct);
   end

   // long receiver hold-off, counted here while the sender keeps going
   initial begin : receiver_hold
      forever begin
         @(posedge clock);
         if (hold_len > 0) begin
            rsp_hold = 1'b1;
            repeat (hold_len) @(posedge clock);
            rsp_hold = 1'b0;
            hold_len = 0;
         end
      end
   end

   task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic [BLOCK_W-1:0] blk,
                           input logic link, input logic [BLOCK_W-1:0] prev);
      fat_result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      want = predict_command(cmd, blk, link, prev);
      pending_replies.push_back(want);
      if (cmd == CMD_FORMAT) pool_count = 0;
      if (cmd == CMD_ALLOC && want.status == ST_OK) begin
         last_alloc           = want.blk;
         alloc_pool[pool_wr]  = want.blk;
         pool_wr              = (pool_wr + 1) % POOL_SIZE;
         if (pool_count < POOL_SIZE) pool_count++;
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {1'b0, prev, link, blk};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      cmds_sent++;
   endtask

   // drop valid and wait on the clock so it is not raised in the same step
   task automatic release_req();
      req_tvalid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_for_replies();
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   function automatic logic [BLOCK_W-1:0] pick_block();
      if (pool_count == 0 || $urandom_range(99) < 15) return BLOCK_W'($urandom);
      return alloc_pool[$urandom_range(pool_count - 1)];
   endfunction

   task automatic random_command();
      int                 roll;
      logic [BLOCK_W-1:0] prev;
      roll = $urandom_range(99);
      if (roll < 2) begin
         send_cmd(CMD_FORMAT, BLOCK_W'($urandom), 1'($urandom), BLOCK_W'($urandom));
      end else if (roll < 42) begin
         case ($urandom_range(9))
            0:       prev = BLOCK_W'($urandom);
            1, 2, 3: prev = pick_block();
            default: prev = last_alloc;
         endcase
         send_cmd(CMD_ALLOC, BLOCK_W'($urandom), 1'($urandom), prev);
      end else if (roll < 58) begin
         send_cmd(CMD_FREE, pick_block(), 1'($urandom), BLOCK_W'($urandom));
      end else if (roll < 74) begin
         send_cmd(CMD_FIND, pick_block(), 1'($urandom), BLOCK_W'($urandom));
      end else if (roll < 92) begin
         send_cmd(CMD_READ, pick_block(), 1'($urandom), BLOCK_W'($urandom));
      end else if (roll < 95) begin
         send_cmd(CMD_W'($urandom_range(CMD_SPARE_C, CMD_SPARE_A)), BLOCK_W'($urandom),
                  1'($urandom), BLOCK_W'($urandom));
      end else begin
         send_cmd(CMD_W'($urandom), BLOCK_W'($urandom), 1'($urandom), BLOCK_W'($urandom));
      end
   endtask

   task automatic test_directed_ops();
      send_cmd(CMD_READ, 11'd0, 1'b0, 11'd0);
      send_cmd(CMD_READ, 11'd2047, 1'b0, 11'd0);
      send_cmd(CMD_ALLOC, 11'd0, 1'b0, 11'd0);
      send_cmd(CMD_ALLOC, 11'd0, 1'b1, 11'd2);
      send_cmd(CMD_ALLOC, 11'd0, 1'b1, 11'd3);
      send_cmd(CMD_FIND, 11'd2, 1'b0, 11'd0);
      send_cmd(CMD_READ, 11'd3, 1'b0, 11'd0);
      // link from a reserved entry, then walk from it
      send_cmd(CMD_ALLOC, 11'd0, 1'b1, 11'd0);
      send_cmd(CMD_READ, 11'd0, 1'b0, 11'd0);
      send_cmd(CMD_FIND, 11'd0, 1'b0, 11'd0);
      // link to itself: the new block stays an end marker
      send_cmd(CMD_ALLOC, 11'd0, 1'b1, 11'd6);
      send_cmd(CMD_READ, 11'd6, 1'b0, 11'd0);
      send_cmd(CMD_FIND, 11'd2047, 1'b0, 11'd0);
      send_cmd(CMD_FREE, 11'd3, 1'b0, 11'd0);
      // walk into the freed tail: head freed, fault where the walk stops
      send_cmd(CMD_FREE, 11'd2, 1'b0, 11'd0);
      send_cmd(CMD_READ, 11'd2, 1'b0, 11'd0);
      send_cmd(CMD_ALLOC, 11'd0, 1'b1, 11'd2047);
      send_cmd(CMD_READ, 11'd2047, 1'b0, 11'd0);
      send_cmd(CMD_FIND, 11'd2047, 1'b0, 11'd0);
      send_cmd(CMD_SPARE_A, 11'd2047, 1'b1, 11'd2047);
      send_cmd(CMD_SPARE_B, 11'd1365, 1'b0, 11'd682);
      send_cmd(CMD_SPARE_C, 11'd2047, 1'b1, 11'd2047);
      send_cmd(CMD_FORMAT, 11'd2047, 1'b1, 11'd2047);
      send_cmd(CMD_READ, 11'd0, 1'b0, 11'd0);
      send_cmd(CMD_READ, 11'd5, 1'b0, 11'd0);
      release_req();
      wait_for_replies();
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct, input int stall_pct);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int i = 0; i < count; i++) random_command();
      release_req();
      wait_for_replies();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      hold_len      = HOLD_CYCLES;
      for (int i = 0; i < 30; i++) random_command();
      release_req();
      wait_for_replies();
   endtask

   initial begin
      format_copy();
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_ops();
      test_random_traffic(240, 0, 0);
      test_random_traffic(230, 57, 0);
      test_backpressure();
      test_random_traffic(230, 0, 57);
      test_random_traffic(220, 23, 23);

      wait_for_replies();
      repeat (64) @(posedge clock);
      $display("run: %0d commands sent, %0d replies checked (%0d chain faults, %0d table full)",
               cmds_sent, replies_ok, fault_count, full_count);
      $display("run: directed ops, random traffic under idle, stalls and a long hold-off");
      if (fail_count == 0 && pending_replies.size() == 0) begin
         $display("testbench: clean");
      end else begin
         $display("failures: %0d, replies still pending: %0d", fail_count,
                  pending_replies.size());
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin : watchdog
      #250_000_000;
      $display("timed out with %0d replies pending", pending_replies.size());
      $display("testbench: errors");
      $finish;
   end

endmodule

// File: fat_block_allocator.f
+incdir+hw/rtl
hw/rtl/fba_pkg.sv
hw/rtl/fba_ram.sv
hw/rtl/fba_ctrl.sv
hw/rtl/fat_block_allocator.sv
tb/testbench.sv
